// File: design/lit_pkg.sv
// Shared types and constants for the linear interpolation table core.
package lit_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = 5;
    localparam int DATA_W     = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_LOW    = 2'd1,
        ST_HIGH   = 2'd2,
        ST_NONE   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MD,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic                  we;
        logic [IDX_W-1:0]      waddr;
        logic [2*DATA_W-1:0]   wdata;
        logic [IDX_W-1:0]      raddr;
    } t_mem_req;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] mag;
        logic [DATA_W-1:0] dq;
        logic [DATA_W-1:0] dx;
    } t_md_req;

endpackage

// File: design/linear_interpolation_table_core.sv
// Top level: piecewise linear interpolation over a loaded breakpoint table.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  command   | start, busy           | i_operation, i_point_index, i_point_x,
//            |                       | i_point_y, i_query_x
//  result    | o_valid (one cycle)   | o_value, o_status
//  config    | i_cfg_we              | i_cfg_wdata (point_count)
//
// A load beat writes its point straight into the memory and leaves the core idle. A query
// scans the table one entry a cycle through the single memory read port, with
// point_count held to 1..16. The result beat comes from the scan when clamped low,
// clamped high or without an interval, and from the 32-step divider when
// interpolated. Reset is synchronous and leaves the table contents undefined; the
// result beat cannot be stalled and lasts exactly one cycle.
module linear_interpolation_table_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_operation,
    input  logic [3:0]                          i_point_index,
    input  logic signed [lit_pkg::DATA_W-1:0]   i_point_x,
    input  logic signed [lit_pkg::DATA_W-1:0]   i_point_y,
    input  logic signed [lit_pkg::DATA_W-1:0]   i_query_x,
    input  logic                                i_cfg_we,
    input  logic [lit_pkg::CNT_W-1:0]           i_cfg_wdata,
    output logic                                o_valid,
    output logic signed [lit_pkg::DATA_W-1:0]   o_value,
    output logic [1:0]                          o_status
);
    import lit_pkg::*;

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_point_count;
    logic [IDX_W-1:0]          r_idx, n_idx;
    logic [IDX_W-1:0]          r_last, n_last;
    logic signed [DATA_W-1:0]  r_q, n_q;
    logic signed [DATA_W-1:0]  r_px, n_px;
    logic signed [DATA_W-1:0]  r_py, n_py;
    logic                      r_found, n_found;
    logic [DATA_W-1:0]         r_y1, n_y1;
    logic                      r_neg, n_neg;
    logic [DATA_W-1:0]         r_mag, n_mag;
    logic [DATA_W-1:0]         r_dq, n_dq;
    logic [DATA_W-1:0]         r_dx, n_dx;
    logic                      r_valid, n_valid;
    logic [DATA_W-1:0]         r_value, n_value;
    t_status                   r_status, n_status;

    logic                      accept;
    logic [IDX_W-1:0]          last_c;
    t_mem_req                  mem_req;
    logic signed [DATA_W-1:0]  rd_x;
    logic signed [DATA_W-1:0]  rd_y;
    t_md_req                   md_req;
    logic                      md_done;
    logic [DATA_W-1:0]         md_quo;
    logic                      at_first;
    logic                      at_last;
    logic                      low_hit;
    logic                      high_hit;
    logic                      seg_hit;
    logic [DATA_W:0]           dy_w;
    logic [DATA_W:0]           dx_w;
    logic [DATA_W:0]           dq_w;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        if (r_point_count == '0) begin
            last_c = '0;
        end else if (int'(r_point_count) > MAX_POINTS) begin
            last_c = IDX_W'(MAX_POINTS - 1);
        end else begin
            last_c = IDX_W'(r_point_count - 1'b1);
        end
    end

    always_comb begin
        mem_req.we    = accept && (i_operation == OP_LOAD) &&
                        (int'(i_point_index) < MAX_POINTS);
        mem_req.waddr = IDX_W'(i_point_index);
        mem_req.wdata = {i_point_x, i_point_y};
        mem_req.raddr = (r_state == S_SCAN) ? r_idx + 1'b1 : '0;
    end

    lit_table_mem u_mem (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rd_x (rd_x),
        .o_rd_y (rd_y)
    );

    always_comb begin
        md_req.start = (r_state == S_MD);
        md_req.mag   = r_mag;
        md_req.dq    = r_dq;
        md_req.dx    = r_dx;
    end

    lit_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .o_done  (md_done),
        .o_quo   (md_quo)
    );

    always_comb begin
        at_first = (r_idx == '0);
        at_last  = (r_idx == r_last);
        low_hit  = at_first && (r_q <= rd_x);
        high_hit = at_last && (r_q >= rd_x);
        seg_hit  = !at_first && (r_q >= r_px) && (r_q < rd_x);
        dy_w     = {rd_y[DATA_W-1], rd_y} - {r_py[DATA_W-1], r_py};
        dx_w     = {rd_x[DATA_W-1], rd_x} - {r_px[DATA_W-1], r_px};
        dq_w     = {r_q[DATA_W-1], r_q} - {r_px[DATA_W-1], r_px};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_operation == OP_QUERY)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (low_hit || high_hit) begin
                    n_state = S_IDLE;
                end else if (at_last) begin
                    n_state = (seg_hit || r_found) ? S_MD : S_IDLE;
                end
            end
            S_MD: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (md_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx    = r_idx;
        n_last   = r_last;
        n_q      = r_q;
        n_px     = r_px;
        n_py     = r_py;
        n_found  = r_found;
        n_y1     = r_y1;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_dq     = r_dq;
        n_dx     = r_dx;
        n_valid  = 1'b0;
        n_value  = r_value;
        n_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_last  = last_c;
                    n_q     = i_query_x;
                    n_found = 1'b0;
                end
            end
            S_SCAN: begin
                if (seg_hit) begin
                    n_found = 1'b1;
                    n_y1    = r_py;
                    n_neg   = dy_w[DATA_W];
                    n_mag   = dy_w[DATA_W] ? DATA_W'(-dy_w) : dy_w[DATA_W-1:0];
                    n_dx    = dx_w[DATA_W-1:0];
                    n_dq    = dq_w[DATA_W-1:0];
                end
                if (low_hit) begin
                    n_valid  = 1'b1;
                    n_value  = rd_y;
                    n_status = ST_LOW;
                end else if (high_hit) begin
                    n_valid  = 1'b1;
                    n_value  = rd_y;
                    n_status = ST_HIGH;
                end else if (at_last) begin
                    if (!(seg_hit || r_found)) begin
                        n_valid  = 1'b1;
                        n_value  = '0;
                        n_status = ST_NONE;
                    end
                end else begin
                    n_px  = rd_x;
                    n_py  = rd_y;
                    n_idx = r_idx + 1'b1;
                end
            end
            S_WAIT: begin
                if (md_done) begin
                    n_valid  = 1'b1;
                    n_value  = r_neg ? r_y1 - md_quo : r_y1 + md_quo;
                    n_status = ST_INTERP;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_point_count <= CNT_W'(2);
            r_valid       <= 1'b0;
            r_found       <= 1'b0;
            r_idx         <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_found <= n_found;
            r_idx   <= n_idx;
            if (i_cfg_we) begin
                r_point_count <= i_cfg_wdata;
            end
        end
        r_last   <= n_last;
        r_q      <= n_q;
        r_px     <= n_px;
        r_py     <= n_py;
        r_y1     <= n_y1;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_dq     <= n_dq;
        r_dx     <= n_dx;
        r_value  <= n_value;
        r_status <= n_status;
    end

    assign o_valid  = r_valid;
    assign o_value  = signed'(r_value);
    assign o_status = r_status;

`ifndef SYNTHESIS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state != S_IDLE))
        else $error("result beat without a query in flight");

    a_none_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NONE)) |-> (o_value == '0))
        else $error("no-interval result carries a nonzero value");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_last))
        else $error("table scan ran past the last point");
`endif

endmodule

// File: design/lit_table_mem.sv
// Breakpoint memory: one write port, one registered read port, x and y side by side.
module lit_table_mem (
    input  logic                                  i_clk,
    input  lit_pkg::t_mem_req                     i_req,
    output logic signed [lit_pkg::DATA_W-1:0]     o_rd_x,
    output logic signed [lit_pkg::DATA_W-1:0]     o_rd_y
);
    import lit_pkg::*;

    logic [2*DATA_W-1:0] r_mem [MAX_POINTS];
    logic [2*DATA_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd <= r_mem[i_req.raddr];
    end

    assign o_rd_x = signed'(r_rd[2*DATA_W-1:DATA_W]);
    assign o_rd_y = signed'(r_rd[DATA_W-1:0]);

endmodule

// File: design/lit_muldiv.sv
// Scaled delta unit: one registered 32x32 multiply, then a one-bit-a-cycle restoring divide.
module lit_muldiv (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lit_pkg::t_md_req              i_req,
    output logic                          o_done,
    output logic [lit_pkg::DATA_W-1:0]    o_quo
);
    import lit_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic                  r_init, n_init;
    logic                  r_run, n_run;
    logic                  r_done, n_done;
    logic [STEP_W-1:0]     r_cnt, n_cnt;
    logic [2*DATA_W-1:0]   r_prod, n_prod;
    logic [DATA_W-1:0]     r_dx, n_dx;
    logic [DATA_W-1:0]     r_rem, n_rem;
    logic [DATA_W-1:0]     r_quo, n_quo;
    logic [DATA_W:0]       rem_sh;
    logic [DATA_W:0]       rem_sub;
    logic                  ge;

    always_comb begin
        rem_sh  = {r_rem, r_quo[DATA_W-1]};
        rem_sub = rem_sh - {1'b0, r_dx};
        ge      = rem_sh >= {1'b0, r_dx};
        n_init  = 1'b0;
        n_run   = r_run;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_prod  = r_prod;
        n_dx    = r_dx;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_req.start) begin
            n_prod = {{DATA_W{1'b0}}, i_req.mag} * {{DATA_W{1'b0}}, i_req.dq};
            n_dx   = i_req.dx;
            n_init = 1'b1;
        end else if (r_init) begin
            // high half is below the divisor, so the quotient fits one word
            n_rem = r_prod[2*DATA_W-1:DATA_W];
            n_quo = r_prod[DATA_W-1:0];
            n_cnt = STEP_W'(DATA_W - 1);
            n_run = 1'b1;
        end else if (r_run) begin
            n_rem = ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            n_quo = {r_quo[DATA_W-2:0], ge};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= 1'b0;
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_init <= n_init;
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_prod <= n_prod;
        r_dx   <= n_dx;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
